// ----- hw/rtl/assert_macros.svh -----
// Shared assertion macros. Each expects clk_i in scope; ASSERT_CLK also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check prop at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/gbe_pkg.sv -----
`timescale 1ns / 1ps

package gbe_pkg;

  localparam int unsigned BufDepthDef = 1024;
  localparam int unsigned ReqW        = 3;
  localparam int unsigned CharW       = 8;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT    = 3'd0,
    REQ_LEFT      = 3'd1,
    REQ_RIGHT     = 3'd2,
    REQ_BACKSPACE = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_READ      = 3'd5
  } req_e;

  // Per-request control from the planner to the pipeline.
  typedef struct packed {
    logic ok;         // request succeeds
    logic re;         // read the store
    logic we;         // write the store as the request leaves the middle stage
    logic wsel_char;  // write data is the inserted byte, not the read byte
    logic rd_out;     // read byte goes to char_out
  } mem_ctl_t;

endpackage

// ----- hw/rtl/gap_buffer_editor_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// in        in_valid_i / in_stall_o    req_type_i, char_in_i, read_index_i
// out       out_valid_o / out_stall_i  ok_o, char_out_o, text_length_o, cursor_at_o
//
// One request is accepted per cycle while in_stall_o is low; its result passes
// the middle stage and then the output register before out_valid_o rises.
// Cursor and gap end update at acceptance; the store read is issued then and
// the store write (insert byte or moved byte) lands as the request leaves the
// middle stage, with a one-deep bypass covering a read issued in that cycle.
// Reset clears cursor and valid bits and sets gap end to BUF_DEPTH; the store is not cleared.
// A stalled result holds the middle stage, which then stalls the input.

module gap_buffer_editor_core #(
  parameter int unsigned BUF_DEPTH = gbe_pkg::BufDepthDef,
  localparam int unsigned AW = $clog2(BUF_DEPTH),
  localparam int unsigned PW = $clog2(BUF_DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [gbe_pkg::ReqW-1:0]  req_type_i,
  input  logic [gbe_pkg::CharW-1:0] char_in_i,
  input  logic [AW-1:0]             read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic [gbe_pkg::CharW-1:0] char_out_o,
  output logic [PW-1:0]             text_length_o,
  output logic [PW-1:0]             cursor_at_o
);

  import gbe_pkg::*;

`include "assert_macros.svh"

  localparam logic [PW-1:0] DepthP = PW'(BUF_DEPTH);

  logic [PW-1:0] cur_q, cur_d, gap_q, gap_d;

  mem_ctl_t      plan_ctl;
  logic [AW-1:0] plan_ra, plan_wa;
  logic [PW-1:0] plan_cur, plan_gap, plan_len;

  logic             s1_vld_q, s1_vld_d;
  mem_ctl_t         s1_ctl_q;
  logic [AW-1:0]    s1_wa_q;
  logic [CharW-1:0] s1_ch_q;
  logic             s1_hit_q;
  logic [PW-1:0]    s1_len_q, s1_cur_q;
  logic [CharW-1:0] fwd_q;

  logic             out_vld_q, out_vld_d;
  logic             ok_q;
  logic [CharW-1:0] char_q;
  logic [PW-1:0]    len_q, curo_q;

  logic             out_free, s1_adv, in_acc, ram_we;
  logic [CharW-1:0] ram_rdata, s1_data, s1_wdata;

  gbe_plan #(.BUF_DEPTH(BUF_DEPTH)) u_plan (
    .req_type_i  (req_type_i),
    .read_index_i(read_index_i),
    .cursor_i    (cur_q),
    .gap_end_i   (gap_q),
    .ctl_o       (plan_ctl),
    .raddr_o     (plan_ra),
    .waddr_o     (plan_wa),
    .cursor_o    (plan_cur),
    .gap_end_o   (plan_gap),
    .length_o    (plan_len)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Bypass the byte written as the read was issued when the RAM returned stale data.
  assign s1_data  = s1_hit_q ? fwd_q : ram_rdata;
  assign s1_wdata = s1_ctl_q.wsel_char ? s1_ch_q : s1_data;
  assign ram_we   = s1_adv && s1_ctl_q.we;

  gbe_ram #(.WIDTH(CharW), .DEPTH(BUF_DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_wa_q),
    .wdata_i(s1_wdata),
    .re_i   (in_acc && plan_ctl.re),
    .raddr_i(plan_ra),
    .rdata_o(ram_rdata)
  );

  assign cur_d     = in_acc ? plan_cur : cur_q;
  assign gap_d     = in_acc ? plan_gap : gap_q;
  assign s1_vld_d  = in_acc || (s1_vld_q && !s1_adv);
  assign out_vld_d = s1_adv || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      gap_q     <= DepthP;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      gap_q     <= gap_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctl_q <= plan_ctl;
      s1_wa_q  <= plan_wa;
      s1_ch_q  <= char_in_i;
      s1_hit_q <= ram_we && plan_ctl.re && (s1_wa_q == plan_ra);
      s1_len_q <= plan_len;
      s1_cur_q <= plan_cur;
    end
    if (ram_we) begin
      fwd_q <= s1_wdata;
    end
    if (s1_adv) begin
      ok_q   <= s1_ctl_q.ok;
      char_q <= s1_ctl_q.rd_out ? s1_data : '0;
      len_q  <= s1_len_q;
      curo_q <= s1_cur_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign ok_o          = ok_q;
  assign char_out_o    = char_q;
  assign text_length_o = len_q;
  assign cursor_at_o   = curo_q;

  `ASSERT_CLK(a_cur_le_gap, cur_q <= gap_q, "cursor passed the gap end")
  `ASSERT_CLK(a_gap_le_depth, gap_q <= DepthP, "gap end beyond capacity")
  `ASSERT_CLK(a_hit_needs_s1, s1_hit_q && s1_vld_q |-> s1_ctl_q.re, "bypass without a read")
  `ASSERT_CLK(a_fail_no_char, out_vld_q && !ok_q |-> char_q == '0, "failed beat carries a byte")
  `ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_vld_q && !s1_vld_q, "pipeline valid in reset")

endmodule

// ----- hw/rtl/gbe_ram.sv -----
`timescale 1ns / 1ps

module gbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on an address collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gbe_plan.sv -----
`timescale 1ns / 1ps

module gbe_plan #(
  parameter int unsigned BUF_DEPTH = gbe_pkg::BufDepthDef,
  localparam int unsigned AW = $clog2(BUF_DEPTH),
  localparam int unsigned PW = $clog2(BUF_DEPTH + 1)
) (
  input  logic [gbe_pkg::ReqW-1:0] req_type_i,
  input  logic [AW-1:0]            read_index_i,
  input  logic [PW-1:0]            cursor_i,
  input  logic [PW-1:0]            gap_end_i,
  output gbe_pkg::mem_ctl_t        ctl_o,
  output logic [AW-1:0]            raddr_o,
  output logic [AW-1:0]            waddr_o,
  output logic [PW-1:0]            cursor_o,
  output logic [PW-1:0]            gap_end_o,
  output logic [PW-1:0]            length_o
);

  import gbe_pkg::*;

  localparam logic [PW-1:0] DepthP = PW'(BUF_DEPTH);

  logic [PW-1:0] cur_m1;
  logic [PW-1:0] gap_m1;
  logic [PW-1:0] len_now;
  logic [PW-1:0] idx_ext;
  logic [PW-1:0] back_addr;

  assign cur_m1    = cursor_i - PW'(1);
  assign gap_m1    = gap_end_i - PW'(1);
  assign len_now   = cursor_i + DepthP - gap_end_i;
  assign idx_ext   = PW'(read_index_i);
  // Skip the gap for indexes at or past the cursor.
  assign back_addr = (idx_ext - cursor_i) + gap_end_i;

  always_comb begin
    ctl_o     = '0;
    ctl_o.ok  = 1'b1;
    raddr_o   = read_index_i;
    waddr_o   = cursor_i[AW-1:0];
    cursor_o  = cursor_i;
    gap_end_o = gap_end_i;
    case (req_e'(req_type_i))
      REQ_INSERT: begin
        if (cursor_i != gap_end_i) begin
          ctl_o.we        = 1'b1;
          ctl_o.wsel_char = 1'b1;
          cursor_o        = cursor_i + PW'(1);
        end else begin
          ctl_o.ok = 1'b0;
        end
      end
      REQ_LEFT: begin
        if (cursor_i != '0) begin
          ctl_o.re  = 1'b1;
          ctl_o.we  = 1'b1;
          raddr_o   = cur_m1[AW-1:0];
          waddr_o   = gap_m1[AW-1:0];
          cursor_o  = cur_m1;
          gap_end_o = gap_m1;
        end
      end
      REQ_RIGHT: begin
        if (gap_end_i != DepthP) begin
          ctl_o.re  = 1'b1;
          ctl_o.we  = 1'b1;
          raddr_o   = gap_end_i[AW-1:0];
          waddr_o   = cursor_i[AW-1:0];
          cursor_o  = cursor_i + PW'(1);
          gap_end_o = gap_end_i + PW'(1);
        end
      end
      REQ_BACKSPACE: begin
        if (cursor_i != '0) begin
          cursor_o = cur_m1;
        end
      end
      REQ_CLEAR: begin
        cursor_o  = '0;
        gap_end_o = DepthP;
      end
      REQ_READ: begin
        if (idx_ext >= len_now) begin
          ctl_o.ok = 1'b0;
        end else begin
          ctl_o.re     = 1'b1;
          ctl_o.rd_out = 1'b1;
          raddr_o      = (idx_ext < cursor_i) ? read_index_i : back_addr[AW-1:0];
        end
      end
      default: begin
        ctl_o.ok = 1'b0;
      end
    endcase
  end

  assign length_o = cursor_o + DepthP - gap_end_o;

endmodule
